// File: sv/swm_pkg.sv
package swm_pkg;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_FIELD_W = 33;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_W      = 6;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic REG_WINDOW_SIZE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_REMOVE,
		ST_INSERT,
		ST_MID,
		ST_EMIT
	} swm_state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic fetch;
		logic remove;
		logic insert;
		logic mid;
		logic emit;
	} swm_cmd_t;

	typedef struct packed {
		logic full;
		logic done;
	} swm_stat_t;

endpackage

// File: sv/swm_ctrl.sv
module swm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  swm_pkg::swm_stat_t stat,
	output swm_pkg::swm_cmd_t  cmd
);

	swm_pkg::swm_state_t state_q, state_nxt;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		cmd.clear  = cfg_write;
		in_ready   = 1'b0;
		unique case (state_q)
			swm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = swm_pkg::ST_FETCH;
				end
			end
			swm_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_nxt = swm_pkg::ST_REMOVE;
			end
			swm_pkg::ST_REMOVE: begin
				cmd.remove = stat.full;
				state_nxt  = swm_pkg::ST_INSERT;
			end
			swm_pkg::ST_INSERT: begin
				cmd.insert = 1'b1;
				state_nxt  = swm_pkg::ST_MID;
			end
			swm_pkg::ST_MID: begin
				cmd.mid   = 1'b1;
				state_nxt = swm_pkg::ST_EMIT;
			end
			swm_pkg::ST_EMIT: begin
				if (!stat.done) begin
					state_nxt = swm_pkg::ST_IDLE;
				end else if (!out_valid_q || out_ready) begin
					cmd.emit  = 1'b1;
					state_nxt = swm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = swm_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: sv/swm_datapath.sv
module swm_datapath #(
	parameter int WINDOW_MAX  = 32,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swm_pkg::swm_cmd_t               cmd,
	input  logic [swm_pkg::CFG_W-1:0]       window_size,
	input  logic [swm_pkg::IN_DATA_W-1:0]   sample,
	input  logic                            restart,
	output swm_pkg::swm_stat_t              stat,
	output logic [swm_pkg::OUT_FIELD_W-1:0] median_x2
);

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);

	logic signed [SAMPLE_BITS-1:0] ring_q [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] sorted_q [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] rm_nxt [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] ins_nxt [WINDOW_MAX];
	logic        [WINDOW_MAX-1:0]  le;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic signed [SAMPLE_BITS-1:0] lo_s1, hi_s1;
	logic        [CW-1:0]          fill_q;
	logic        [AW-1:0]          oldest_q;
	logic        [AW-1:0]          oldest_inc;
	logic        [AW:0]            slot_sum;
	logic        [AW-1:0]          slot;
	logic        [CW-1:0]          k;
	logic        [swm_pkg::CFG_W-1:0] ws_eff;
	logic        [AW-1:0]          lo_idx, hi_idx;
	logic        [SAMPLE_BITS:0]   sum;
	logic [swm_pkg::OUT_FIELD_W-1:0] median_q;

	always_comb begin
		if (window_size == '0)
			ws_eff = swm_pkg::CFG_W'(1);
		else if (int'(window_size) > WINDOW_MAX)
			ws_eff = swm_pkg::CFG_W'(WINDOW_MAX);
		else
			ws_eff = window_size;
		k = CW'(ws_eff);
	end

	assign lo_idx = AW'((k - CW'(1)) >> 1);
	assign hi_idx = AW'(k >> 1);

	assign oldest_inc = (int'(oldest_q) == WINDOW_MAX - 1) ? '0 : oldest_q + AW'(1);
	assign slot_sum   = (AW + 1)'(oldest_q) + (AW + 1)'(fill_q);
	assign slot       = (int'(slot_sum) >= WINDOW_MAX) ?
		AW'(slot_sum - (AW + 1)'(WINDOW_MAX)) : AW'(slot_sum);

	assign stat.full = (fill_q >= k);
	assign stat.done = (fill_q == k);

	always_comb begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (sorted_q[i] < old_q || i == WINDOW_MAX - 1)
				rm_nxt[i] = sorted_q[i];
			else
				rm_nxt[i] = sorted_q[(i + 1) % WINDOW_MAX];
		end
		for (int j = 0; j < WINDOW_MAX; j++)
			le[j] = (j < int'(fill_q)) && (sorted_q[j] <= x_q);
		for (int j = 0; j < WINDOW_MAX; j++) begin
			if (le[j])
				ins_nxt[j] = sorted_q[j];
			else if (j == 0)
				ins_nxt[j] = x_q;
			else if (le[(j + WINDOW_MAX - 1) % WINDOW_MAX])
				ins_nxt[j] = x_q;
			else
				ins_nxt[j] = sorted_q[(j + WINDOW_MAX - 1) % WINDOW_MAX];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			oldest_q <= '0;
		end else begin
			priority if (cmd.clear || (cmd.load && restart)) begin
				fill_q   <= '0;
				oldest_q <= '0;
			end else if (cmd.remove) begin
				fill_q   <= fill_q - CW'(1);
				oldest_q <= oldest_inc;
			end else if (cmd.insert) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			x_q <= sample[SAMPLE_BITS-1:0];
		if (cmd.fetch)
			old_q <= ring_q[oldest_q];
		if (cmd.insert)
			ring_q[slot] <= x_q;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (cmd.remove)
				sorted_q[i] <= rm_nxt[i];
			else if (cmd.insert)
				sorted_q[i] <= ins_nxt[i];
		end
		if (cmd.mid) begin
			lo_s1 <= sorted_q[lo_idx];
			hi_s1 <= sorted_q[hi_idx];
		end
		if (cmd.emit)
			median_q <= swm_pkg::OUT_FIELD_W'(sum);
	end

	assign sum       = (SAMPLE_BITS + 1)'(lo_s1) + (SAMPLE_BITS + 1)'(hi_s1);
	assign median_x2 = median_q;

endmodule

// File: sv/sliding_window_median.sv
// Streaming median filter over the last window_size signed samples (0 acts as 1, sizes
// above WINDOW_MAX act as WINDOW_MAX). Each accepted word enters the window (tuser high
// empties the window first); once the window holds that many samples, every word yields
// twice the median on the master side. A result is presented after the sequencer steps
// through the arrival ring read, a removal pass when the window is full and an insertion
// pass over the sorted cell row, the middle-cell select and the output load; a new word
// is taken only in idle; a result waiting on the master side stalls the output load.
// Writing window_size empties the window. No clearing pass follows reset.
module sliding_window_median #(
	parameter int WINDOW_MAX  = 32,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [swm_pkg::IN_DATA_W-1:0]   s_tdata,  // [31:0] sample
	input  logic                            s_tuser,  // [0] restart
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [swm_pkg::OUT_DATA_W-1:0]  m_tdata,  // [32:0] median_x2, zero above
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [swm_pkg::PADDR_W-1:0]     paddr,
	input  logic [swm_pkg::PDATA_W-1:0]     pwdata,
	output logic [swm_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);

	swm_pkg::swm_cmd_t  cmd;
	swm_pkg::swm_stat_t stat;
	logic [swm_pkg::CFG_W-1:0]       window_size_q;
	logic [swm_pkg::OUT_FIELD_W-1:0] median_x2;
	logic                            cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready &&
		(paddr[2] == swm_pkg::REG_WINDOW_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_size_q <= swm_pkg::CFG_W'(1);
		else if (cfg_write)
			window_size_q <= pwdata[swm_pkg::CFG_W-1:0];
	end

	assign prdata = (paddr[2] == swm_pkg::REG_WINDOW_SIZE) ?
		swm_pkg::PDATA_W'(window_size_q) : '0;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	swm_datapath #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.window_size (window_size_q),
		.sample      (s_tdata),
		.restart     (s_tuser),
		.stat        (stat),
		.median_x2   (median_x2)
	);

	assign m_tdata = swm_pkg::OUT_DATA_W'(median_x2);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a word is in work");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised without a word in work");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.fetch, cmd.remove, cmd.insert, cmd.mid, cmd.emit}))
		else $error("more than one sequencer step at once");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int REG_UNUSED = 1;
	localparam logic [swm_pkg::PADDR_W-1:0] ADDR_WINDOW_SIZE =
		swm_pkg::PADDR_W'(int'(swm_pkg::REG_WINDOW_SIZE) * 4);
	localparam logic [swm_pkg::PADDR_W-1:0] ADDR_UNUSED = swm_pkg::PADDR_W'(REG_UNUSED * 4);
	localparam int WIN_CAP = 32;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic [31:0] sample;
		logic        restart;
	} sample_word_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [swm_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // [31:0] sample
	logic                           s_tuser = 1'b0; // [0] restart
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [swm_pkg::OUT_DATA_W-1:0] m_tdata;        // [32:0] median_x2, zero above
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [swm_pkg::PADDR_W-1:0]    paddr = '0;
	logic [swm_pkg::PDATA_W-1:0]    pwdata = '0;
	logic [swm_pkg::PDATA_W-1:0]    prdata;
	logic                           pready;

	sample_word_t          pending_words[$];
	sample_word_t          next_word;
	logic signed [32:0]    median_x2_q[$];
	logic signed [32:0]    want_median;
	int unsigned           send_idle_pct = 0;
	int unsigned           recv_stall_pct = 0;
	int unsigned           errors = 0;

	logic signed [31:0]    arrival_vals[WIN_CAP];
	logic signed [31:0]    sorted_vals[WIN_CAP];
	int                    fill_count = 0;
	int                    oldest_slot = 0;
	logic [swm_pkg::CFG_W-1:0] window_reg = 6'd1;

	sliding_window_median dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	task automatic log_mismatch(input string what, input logic [39:0] want, input logic [39:0] got);
		if (errors < 10)
			$display("%0t %s: expected %h, got %h", $realtime, what, want, got);
		errors++;
	endtask

	task automatic window_push(input logic [31:0] raw, input logic restart);
		int                 k;
		int                 pos;
		int                 i;
		bit                 found;
		logic signed [31:0] x;
		logic signed [31:0] old;
		logic signed [32:0] m;
		k = (window_reg == 0) ? 1 : ((window_reg > WIN_CAP) ? WIN_CAP : int'(window_reg));
		x = raw;
		if (restart) begin
			fill_count = 0;
			oldest_slot = 0;
		end
		if (fill_count >= k) begin
			old = arrival_vals[oldest_slot];
			found = 1'b0;
			pos = 0;
			for (i = 0; i < fill_count; i++)
				if (!found && sorted_vals[i] == old) begin
					found = 1'b1;
					pos = i;
				end
			for (i = pos; i < fill_count - 1; i++)
				sorted_vals[i] = sorted_vals[i + 1];
			oldest_slot = (oldest_slot + 1) % WIN_CAP;
			fill_count--;
		end
		arrival_vals[(oldest_slot + fill_count) % WIN_CAP] = x;
		pos = 0;
		while (pos < fill_count && sorted_vals[pos] <= x)
			pos++;
		for (i = fill_count; i > pos; i--)
			sorted_vals[i] = sorted_vals[i - 1];
		sorted_vals[pos] = x;
		fill_count++;
		if (fill_count == k) begin
			if (k % 2 == 0)
				m = {sorted_vals[k/2-1][31], sorted_vals[k/2-1]} +
					{sorted_vals[k/2][31], sorted_vals[k/2]};
			else
				m = {sorted_vals[k/2], 1'b0};
			median_x2_q.insert(median_x2_q.size(), m);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				window_push(s_tdata, s_tuser);
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_word.sample;
					s_tuser <= next_word.restart;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (median_x2_q.size() == 0) begin
					log_mismatch("unexpected word", '0, m_tdata);
				end else begin
					want_median = median_x2_q.pop_front();
					if (m_tdata !== {{(swm_pkg::OUT_DATA_W-swm_pkg::OUT_FIELD_W){1'b0}},
							want_median})
						log_mismatch("median_x2",
							{{(swm_pkg::OUT_DATA_W-swm_pkg::OUT_FIELD_W){1'b0}}, want_median},
							m_tdata);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic apb_write(input logic [swm_pkg::PADDR_W-1:0] addr,
			input logic [swm_pkg::PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_WINDOW_SIZE) begin
			window_reg = data[swm_pkg::CFG_W-1:0];
			fill_count = 0;
			oldest_slot = 0;
		end
	endtask

	task automatic apb_read(input logic [swm_pkg::PADDR_W-1:0] addr,
			output logic [swm_pkg::PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic settle_idle();
		do @(posedge clk);
		while (pending_words.size() != 0 || s_tvalid || median_x2_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [swm_pkg::CFG_W-1:0] size);
		logic [swm_pkg::PDATA_W-1:0] wdata;
		logic [swm_pkg::PDATA_W-1:0] rdata;
		settle_idle();
		wdata = {26'($urandom()), size};
		apb_write(ADDR_WINDOW_SIZE, wdata);
		apb_read(ADDR_WINDOW_SIZE, rdata);
		if (rdata !== {{(swm_pkg::PDATA_W-swm_pkg::CFG_W){1'b0}}, size})
			log_mismatch("window_size readback",
				{8'b0, {(swm_pkg::PDATA_W-swm_pkg::CFG_W){1'b0}}, size}, {8'b0, rdata});
	endtask

	task automatic push_word(input logic [31:0] sample, input logic restart);
		sample_word_t w;
		w.sample = sample;
		w.restart = restart;
		pending_words.insert(pending_words.size(), w);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(9))
			0: return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
			1, 2, 3: return 32'($urandom_range(8)) - 32'd4;
			default: return $urandom();
		endcase
	endfunction

	task automatic run_phase(input logic [swm_pkg::CFG_W-1:0] size, input int unsigned idle_pct,
			input int unsigned stall_pct, input int count);
		set_window(size);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) push_word(pick_sample(), $urandom_range(99) < 3);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (!arst_n);

		push_word(32'h8000_0000, 1'b0);
		push_word(32'h7fff_ffff, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'hffff_ffff, 1'b0);
		push_word(32'd1, 1'b1);

		set_window(6'd2);
		push_word(32'h8000_0000, 1'b0);
		push_word(32'h8000_0000, 1'b0);
		push_word(32'h7fff_ffff, 1'b0);
		push_word(32'h7fff_ffff, 1'b0);
		push_word(32'd5, 1'b1);
		push_word(32'd6, 1'b0);

		set_window(6'd3);
		push_word(32'd7, 1'b0);
		push_word(32'd7, 1'b0);
		push_word(32'd7, 1'b0);
		push_word(32'd3, 1'b0);
		push_word(32'd7, 1'b0);

		settle_idle();
		apb_write(ADDR_UNUSED, $urandom());
		push_word(32'd9, 1'b0);

		set_window(6'd0);
		push_word(32'd5, 1'b0);
		push_word(-32'sd5, 1'b0);

		run_phase(6'd63, 0, 0, 100);
		run_phase(6'($urandom_range(2, 31)), 74, 0, 120);
		run_phase(6'd32, 0, 74, 120);
		run_phase(6'd33, 38, 38, 100);
		run_phase(6'($urandom_range(1, 8)), 0, 0, 80);
		run_phase(6'd1, 38, 38, 50);

		settle_idle();
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: sim.f
sv/swm_pkg.sv
sv/swm_ctrl.sv
sv/swm_datapath.sv
sv/sliding_window_median.sv
tb/testbench.sv
